[rtl/npnp_pkg.sv]
// Shared types, constants and state codes for the nearest-point position block.
package npnp_pkg;

    localparam int MAX_POINTS_DEF = 256;
    localparam int COORD_BITS_DEF = 24;
    localparam int IN_COORD_W     = 24;
    localparam int DIST_W         = 26;
    localparam int RATIO_W        = 17;
    localparam int SQ_W           = 2 * (COORD_BITS_DEF + 1) + 1;

    typedef enum logic [1:0] {
        KIND_LOAD_FIRST  = 2'd0,
        KIND_LOAD_SECOND = 2'd1,
        KIND_QUERY       = 2'd2,
        KIND_CLEAR       = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]                   kind;
        logic signed [IN_COORD_W-1:0] coord_x;
        logic signed [IN_COORD_W-1:0] coord_y;
    } in_word_t;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic [DIST_W-1:0]  first_distance;
        logic [DIST_W-1:0]  second_distance;
        logic               degenerate;
        logic               overflow;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_REQ,
        ST_SCAN_MUL,
        ST_SCAN_CMP,
        ST_SQRT,
        ST_NEXT_SET,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } unit_ctl_t;

endpackage

[rtl/npnp_sqrt.sv]
// Bit-serial integer square root, two radicand bits per cycle.
module npnp_sqrt import npnp_pkg::*; #(
    parameter int SQ_BITS = SQ_W,
    parameter int RT_BITS = DIST_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [SQ_BITS-1:0] radicand,
    output unit_ctl_t          ctl,
    output logic [RT_BITS-1:0] root
);
    localparam int STEPS = (SQ_BITS + 1) / 2;
    localparam int RW    = 2 * STEPS;
    localparam int CW    = $clog2(STEPS + 1);

    logic [RW-1:0]      v_reg, v_next;
    logic [RW+1:0]      rem_reg, rem_next;
    logic [STEPS-1:0]   r_reg, r_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [RW+1:0]      trial;
    logic [RW+1:0]      shifted;

    always_comb begin
        v_next   = v_reg;
        rem_next = rem_reg;
        r_next   = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        shifted  = {rem_reg[RW-1:0], v_reg[RW-1 -: 2]};
        trial    = {{(RW+2-STEPS-2){1'b0}}, r_reg, 2'b01};
        if (start) begin
            v_next    = RW'(radicand);
            rem_next  = '0;
            r_next    = '0;
            cnt_next  = CW'(STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            v_next = {v_reg[RW-3:0], 2'b00};
            if (shifted >= trial) begin
                rem_next = shifted - trial;
                r_next   = {r_reg[STEPS-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                r_next   = {r_reg[STEPS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        v_reg   <= v_next;
        rem_reg <= rem_next;
        r_reg   <= r_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg | start;
    assign root      = RT_BITS'(r_reg);

endmodule

[rtl/npnp_div.sv]
// Restoring divider, one quotient bit per cycle, for the rounded position ratio.
module npnp_div import npnp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DIST_W-1:0]  d1,
    input  logic [DIST_W-1:0]  d2,
    output unit_ctl_t          ctl,
    output logic [RATIO_W-1:0] quot
);
    localparam int SW = DIST_W + 1;
    localparam int NW = DIST_W + 17;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg, num_next;
    logic [SW-1:0] den_reg, den_next;
    logic [SW:0]   rem_reg, rem_next;
    logic [NW-1:0] q_reg, q_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [SW-1:0] sum;
    logic [SW:0]   sh;

    always_comb begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        sum = SW'(d1) + SW'(d2);
        sh  = {rem_reg[SW-1:0], num_reg[NW-1]};
        if (start) begin
            num_next  = {1'b0, d2, 16'd0} + NW'(sum >> 1);
            den_next  = sum;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[NW-2:0], 1'b0};
            if (sh >= {1'b0, den_reg}) begin
                rem_next = sh - {1'b0, den_reg};
                q_next   = {q_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = sh;
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg | start;
    assign quot      = RATIO_W'(q_reg);

endmodule

[rtl/nearest_point_normalized_position.sv]
// Top level: point-set storage, scan sequencer, shared root unit, divide unit.
// A query scans each set through one memory read port and one
// squared-distance unit, in states ST_SCAN_REQ, ST_SCAN_MUL and ST_SCAN_CMP
// for each point, and runs a 26-step square root per set, then a 43-step
// divide. An empty set is scanned as one point at the origin. The result
// stays in an output register until taken; loads and clears are still
// accepted while it waits, and no word is accepted during a query.
module nearest_point_normalized_position import npnp_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);
    localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNW = $clog2(MAX_POINTS + 1);
    localparam int DW  = COORD_BITS + 1;
    localparam int LSQ = 2 * DW + 1;

    logic [2*COORD_BITS-1:0] mem1 [MAX_POINTS];
    logic [2*COORD_BITS-1:0] mem2 [MAX_POINTS];
    logic [2*COORD_BITS-1:0] rd1_reg, rd2_reg;

    state_t          state_reg, state_next;
    logic [CNW-1:0]  cnt1_reg, cnt1_next, cnt2_reg, cnt2_next;
    logic            ovf_reg, ovf_next;
    logic [CNW-1:0]  idx_reg, idx_next;
    logic            set_reg, set_next;
    logic signed [COORD_BITS-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic [LSQ-1:0]  best_reg, best_next;
    logic [LSQ-1:0]  sqx_reg, sqy_reg;
    logic [DIST_W-1:0] d1_reg, d1_next, d2_reg, d2_next;
    logic            mv_reg, mv_next;
    out_word_t       out_reg, out_next;
    logic            sq_start, dv_start;
    unit_ctl_t       sq_ctl, dv_ctl;
    logic [DIST_W-1:0]  root;
    logic [RATIO_W-1:0] quot;

    logic signed [COORD_BITS-1:0] in_x, in_y, px, py;
    logic signed [DW-1:0]         dx, dy;
    logic [DW-1:0]                ax, ay;
    logic [2*DW-1:0]              sqx_w, sqy_w;
    logic [LSQ-1:0]               dsum;
    logic [CNW-1:0]               cur_cnt;
    logic                         wr1, wr2;

    assign in_x = s_data.coord_x[COORD_BITS-1:0];
    assign in_y = s_data.coord_y[COORD_BITS-1:0];
    assign cur_cnt = set_reg ? cnt2_reg : cnt1_reg;
    assign px = (cur_cnt == '0) ? '0 :
                (set_reg ? rd2_reg[2*COORD_BITS-1 -: COORD_BITS]
                         : rd1_reg[2*COORD_BITS-1 -: COORD_BITS]);
    assign py = (cur_cnt == '0) ? '0 :
                (set_reg ? rd2_reg[COORD_BITS-1:0] : rd1_reg[COORD_BITS-1:0]);
    assign dx = DW'(qx_reg) - DW'(px);
    assign dy = DW'(qy_reg) - DW'(py);
    assign ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
    assign ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
    assign sqx_w = ax * ax;
    assign sqy_w = ay * ay;
    assign dsum = sqx_reg + sqy_reg;
    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (wr1) begin
            mem1[cnt1_reg[AW-1:0]] <= {in_x, in_y};
        end
        if (wr2) begin
            mem2[cnt2_reg[AW-1:0]] <= {in_x, in_y};
        end
        rd1_reg <= mem1[idx_reg[AW-1:0]];
        rd2_reg <= mem2[idx_reg[AW-1:0]];
        sqx_reg <= LSQ'(sqx_w);
        sqy_reg <= LSQ'(sqy_w);
    end

    always_comb begin
        state_next = state_reg;
        cnt1_next = cnt1_reg;
        cnt2_next = cnt2_reg;
        ovf_next = ovf_reg;
        idx_next = idx_reg;
        set_next = set_reg;
        qx_next = qx_reg;
        qy_next = qy_reg;
        best_next = best_reg;
        d1_next = d1_reg;
        d2_next = d2_reg;
        mv_next = mv_reg;
        out_next = out_reg;
        sq_start = 1'b0;
        dv_start = 1'b0;
        wr1 = 1'b0;
        wr2 = 1'b0;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    case (kind_t'(s_data.kind))
                        KIND_LOAD_FIRST: begin
                            if (cnt1_reg < CNW'(MAX_POINTS)) begin
                                wr1 = 1'b1;
                                cnt1_next = cnt1_reg + 1'b1;
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        KIND_LOAD_SECOND: begin
                            if (cnt2_reg < CNW'(MAX_POINTS)) begin
                                wr2 = 1'b1;
                                cnt2_next = cnt2_reg + 1'b1;
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        KIND_CLEAR: begin
                            cnt1_next = '0;
                            cnt2_next = '0;
                            ovf_next = 1'b0;
                        end
                        KIND_QUERY: begin
                            qx_next = in_x;
                            qy_next = in_y;
                            idx_next = '0;
                            set_next = 1'b0;
                            best_next = '1;
                            state_next = ST_SCAN_REQ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN_REQ: state_next = ST_SCAN_MUL;
            ST_SCAN_MUL: state_next = ST_SCAN_CMP;
            ST_SCAN_CMP: begin
                if (dsum < best_reg) begin
                    best_next = dsum;
                end
                if (idx_reg + 1'b1 >= cur_cnt) begin
                    state_next = ST_NEXT_SET;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_SCAN_REQ;
                end
            end
            ST_NEXT_SET: begin
                sq_start = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                if (!sq_ctl.busy) begin
                    if (!set_reg) begin
                        d1_next = root;
                        set_next = 1'b1;
                        idx_next = '0;
                        best_next = '1;
                        state_next = ST_SCAN_REQ;
                    end else begin
                        d2_next = root;
                        dv_start = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (!dv_ctl.busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!mv_reg) begin
                    out_next.first_distance  = d1_reg;
                    out_next.second_distance = d2_reg;
                    out_next.degenerate = (d1_reg == '0) && (d2_reg == '0);
                    out_next.ratio = out_next.degenerate ? '0 : quot;
                    out_next.overflow = ovf_reg;
                    mv_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        qx_reg <= qx_next;
        qy_reg <= qy_next;
        best_reg <= best_next;
        d1_reg <= d1_next;
        d2_reg <= d2_next;
        out_reg <= out_next;
        idx_reg <= idx_next;
        set_reg <= set_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt1_reg <= '0;
            cnt2_reg <= '0;
            ovf_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt1_reg <= cnt1_next;
            cnt2_reg <= cnt2_next;
            ovf_reg <= ovf_next;
            mv_reg <= mv_next;
        end
    end

    npnp_sqrt #(.SQ_BITS(LSQ), .RT_BITS(DIST_W)) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start),
        .radicand(best_reg), .ctl(sq_ctl), .root(root)
    );

    npnp_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start),
        .d1(d1_reg), .d2(d2_next), .ctl(dv_ctl), .quot(quot)
    );

    assign m_valid = mv_reg;
    assign m_data  = out_reg;

endmodule
